### rtl/quoted_escaped_field_splitter_defines.svh
// Assertion macros for the quoted escaped field splitter
`ifndef QUOTED_ESCAPED_FIELD_SPLITTER_DEFINES_SVH
`define QUOTED_ESCAPED_FIELD_SPLITTER_DEFINES_SVH

// check a property at every clock edge out of reset
`define QEFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check that a condition implies another one on the next edge
`define QEFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qefs_pkg.sv
// Package with types and constants of the quoted escaped field splitter
package qefs_pkg;

    localparam int FIELD_COUNT_BITS_DEFAULT = 8;
    localparam int CFG_INDEX_BITS           = 3;
    localparam int CFG_DATA_BITS            = 64;
    localparam int QUEUE_DEPTH              = 4;
    localparam int QUEUE_PTR_BITS           = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DELIM_MAP_0 = 3'd0,
        REG_DELIM_MAP_1 = 3'd1,
        REG_DELIM_MAP_2 = 3'd2,
        REG_DELIM_MAP_3 = 3'd3,
        REG_MAX_FIELDS  = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] field_number;
        logic       last;
    } result_t;

    function automatic result_t make_result(kind_t k, logic [7:0] d, logic [7:0] f);
        result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.field_number = f;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] escape_byte(logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_LOWER_B: r = CH_BS;
            CH_LOWER_N: r = CH_LF;
            CH_LOWER_R: r = CH_CR;
            CH_LOWER_T: r = CH_TAB;
            default:    r = b;
        endcase
        return r;
    endfunction

endpackage

### rtl/quoted_escaped_field_splitter.sv
// Top level of the quoted escaped field splitter: byte decoder and result queue
// Results of an accepted byte are registered into the result queue and leave from its head.
// Throughput: one input byte per cycle while in_ready is high; a byte yields at most two results,
// which drain one per cycle while out_ready is high from a four-entry result queue.
// Input is ready while at least two queue entries are free.
// Reset clears the record state, queue and registers (max_fields to 16).
`include "quoted_escaped_field_splitter_defines.svh"

module quoted_escaped_field_splitter #(
    parameter int FIELD_COUNT_BITS = qefs_pkg::FIELD_COUNT_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qefs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [qefs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           in_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           kind,
    output logic [7:0]                           data_byte,
    output logic [7:0]                           field_number,
    output logic                                 last
);

    import qefs_pkg::*;

    localparam int CW = FIELD_COUNT_BITS + 9;

    logic [3:0][63:0]              delim_map_reg;
    logic [7:0]                    max_fields_reg;

    logic                          in_quotes_reg, in_quotes_next;
    logic                          after_backslash_reg, after_backslash_next;
    logic                          octal_active_reg, octal_active_next;
    logic [7:0]                    octal_value_reg, octal_value_next;
    logic                          at_field_start_reg, at_field_start_next;
    logic [FIELD_COUNT_BITS-1:0]   field_index_reg, field_index_next;
    logic                          discarding_reg, discarding_next;

    result_t                       queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]     head_reg, head_next;
    logic [QUEUE_PTR_BITS-1:0]     tail_reg, tail_next;
    logic [QUEUE_CNT_BITS-1:0]     count_reg, count_next;

    result_t                       new_res [2];
    logic [1:0]                    push_cnt;
    logic                          in_fire;
    logic                          out_fire;
    logic                          is_delim;
    logic                          is_octal;
    logic                          is_blank;
    logic [FIELD_COUNT_BITS+7:0]   idx_wide;
    logic [FIELD_COUNT_BITS+7:0]   idx_inc_wide;
    logic [FIELD_COUNT_BITS-1:0]   idx_inc;
    logic [7:0]                    fnum_cur;
    logic [7:0]                    fnum_inc;
    logic                          over_limit;
    logic [CW-1:0]                 idx_plus2;
    logic [CW-1:0]                 mf_ext;

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;

    assign kind         = queue_reg[head_reg].kind;
    assign data_byte    = queue_reg[head_reg].data_byte;
    assign field_number = queue_reg[head_reg].field_number;
    assign last         = queue_reg[head_reg].last;

    assign is_delim  = (in_byte != CH_NUL) && delim_map_reg[in_byte[7:6]][in_byte[5:0]];
    assign is_octal  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    assign is_blank  = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

    assign idx_inc      = field_index_reg + 1'b1;
    assign idx_wide     = {8'b0, field_index_reg};
    assign idx_inc_wide = {8'b0, idx_inc};
    assign fnum_cur     = idx_wide[7:0];
    assign fnum_inc     = idx_inc_wide[7:0];
    assign idx_plus2    = CW'(field_index_reg) + CW'(2);
    assign mf_ext       = CW'(max_fields_reg);
    assign over_limit   = (idx_plus2 >= mf_ext);

    // decode one byte
    always_comb
    begin
        logic done;
        logic end_rec;
        done                 = 1'b0;
        end_rec              = 1'b0;
        push_cnt             = 2'd0;
        new_res[0]           = make_result(KIND_DATA, 8'h00, 8'h00);
        new_res[1]           = make_result(KIND_DATA, 8'h00, 8'h00);
        in_quotes_next       = in_quotes_reg;
        after_backslash_next = after_backslash_reg;
        octal_active_next    = octal_active_reg;
        octal_value_next     = octal_value_reg;
        at_field_start_next  = at_field_start_reg;
        field_index_next     = field_index_reg;
        discarding_next      = discarding_reg;

        if (in_fire)
        begin
            if (discarding_reg)
            begin
                done    = 1'b1;
                end_rec = (in_byte == CH_NUL);
            end
            else if (at_field_start_reg)
            begin
                if (over_limit)
                begin
                    new_res[0] = make_result(KIND_ERROR, 8'h00, fnum_cur);
                    push_cnt   = 2'd1;
                    done       = 1'b1;
                    if (in_byte == CH_NUL)
                    begin
                        end_rec = 1'b1;
                    end
                    else
                    begin
                        discarding_next = 1'b1;
                    end
                end
                else if (is_blank)
                begin
                    done = 1'b1;
                end
                else
                begin
                    at_field_start_next = 1'b0;
                end
            end

            if (!done)
            begin
                if (after_backslash_reg)
                begin
                    after_backslash_next = 1'b0;
                    if (in_byte == CH_NUL)
                    begin
                        new_res[0] = make_result(KIND_RECORD_END, 8'h00, fnum_inc);
                        push_cnt   = 2'd1;
                        end_rec    = 1'b1;
                    end
                    else if (is_octal)
                    begin
                        octal_active_next = 1'b1;
                        octal_value_next  = {5'b0, in_byte[2:0]};
                    end
                    else
                    begin
                        new_res[0] = make_result(KIND_DATA, escape_byte(in_byte), fnum_cur);
                        push_cnt   = 2'd1;
                    end
                end
                else
                begin
                    if (octal_active_reg)
                    begin
                        if (is_octal)
                        begin
                            octal_value_next = {octal_value_reg[4:0], in_byte[2:0]};
                            done             = 1'b1;
                        end
                        else
                        begin
                            new_res[0] = make_result(KIND_DATA, octal_value_reg, fnum_cur);
                            push_cnt          = 2'd1;
                            octal_active_next = 1'b0;
                            octal_value_next  = 8'h00;
                        end
                    end
                    if (!done)
                    begin
                        if (in_byte == CH_NUL)
                        begin
                            new_res[push_cnt[0]] =
                                make_result(KIND_RECORD_END, 8'h00, fnum_inc);
                            push_cnt = push_cnt + 2'd1;
                            end_rec  = 1'b1;
                        end
                        else if (is_delim)
                        begin
                            if (in_quotes_reg)
                            begin
                                new_res[push_cnt[0]] =
                                    make_result(KIND_DATA, in_byte, fnum_cur);
                            end
                            else
                            begin
                                new_res[push_cnt[0]] =
                                    make_result(KIND_FIELD_END, 8'h00, fnum_cur);
                                field_index_next    = idx_inc;
                                at_field_start_next = 1'b1;
                            end
                            push_cnt = push_cnt + 2'd1;
                        end
                        else if (in_byte == CH_QUOTE)
                        begin
                            in_quotes_next = !in_quotes_reg;
                        end
                        else if (in_byte == CH_BACKSLASH)
                        begin
                            after_backslash_next = 1'b1;
                        end
                        else
                        begin
                            new_res[push_cnt[0]] = make_result(KIND_DATA, in_byte, fnum_cur);
                            push_cnt = push_cnt + 2'd1;
                        end
                    end
                end
            end

            // return to the record start state
            if (end_rec)
            begin
                in_quotes_next       = 1'b0;
                after_backslash_next = 1'b0;
                octal_active_next    = 1'b0;
                octal_value_next     = 8'h00;
                at_field_start_next  = 1'b1;
                field_index_next     = '0;
                discarding_next      = 1'b0;
            end

            if (push_cnt == 2'd2)
            begin
                new_res[1].last = 1'b1;
            end
            else if (push_cnt == 2'd1)
            begin
                new_res[0].last = 1'b1;
            end
        end
    end

    always_comb
    begin
        head_next  = head_reg + QUEUE_PTR_BITS'(out_fire);
        tail_next  = tail_reg + QUEUE_PTR_BITS'(push_cnt);
        count_next = count_reg + QUEUE_CNT_BITS'(push_cnt) - QUEUE_CNT_BITS'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_map_reg       <= '0;
            max_fields_reg      <= MAX_FIELDS_RESET;
            in_quotes_reg       <= 1'b0;
            after_backslash_reg <= 1'b0;
            octal_active_reg    <= 1'b0;
            octal_value_reg     <= 8'h00;
            at_field_start_reg  <= 1'b1;
            field_index_reg     <= '0;
            discarding_reg      <= 1'b0;
            head_reg            <= '0;
            tail_reg            <= '0;
            count_reg           <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DELIM_MAP_0: delim_map_reg[0] <= cfg_data;
                    REG_DELIM_MAP_1: delim_map_reg[1] <= cfg_data;
                    REG_DELIM_MAP_2: delim_map_reg[2] <= cfg_data;
                    REG_DELIM_MAP_3: delim_map_reg[3] <= cfg_data;
                    REG_MAX_FIELDS:  max_fields_reg   <= cfg_data[7:0];
                    default:         ;
                endcase
            end
            in_quotes_reg       <= in_quotes_next;
            after_backslash_reg <= after_backslash_next;
            octal_active_reg    <= octal_active_next;
            octal_value_reg     <= octal_value_next;
            at_field_start_reg  <= at_field_start_next;
            field_index_reg     <= field_index_next;
            discarding_reg      <= discarding_next;
            head_reg            <= head_next;
            tail_reg            <= tail_next;
            count_reg           <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[tail_reg] <= new_res[0];
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[tail_reg + QUEUE_PTR_BITS'(1)] <= new_res[1];
        end
    end

    `QEFS_ASSERT(a_count_bound, count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue overflow")
    `QEFS_ASSERT(a_ready_room, !in_ready || (count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2)), "no room for request")
    `QEFS_ASSERT(a_escape_excl, !(octal_active_reg && after_backslash_reg), "octal and escape both set")
    `QEFS_ASSERT_NEXT(a_term_clears, in_fire && (in_byte == CH_NUL), at_field_start_reg && (field_index_reg == '0) && !discarding_reg, "terminator did not clear record")
    `QEFS_ASSERT_NEXT(a_pop_count, out_fire && (push_cnt == 2'd0), count_reg == $past(count_reg) - QUEUE_CNT_BITS'(1), "pop count mismatch")

endmodule

### tb/tb.sv
// Self-checking testbench for the quoted escaped field splitter: directed script plus random records
module tb;
    import qefs_pkg::*;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam int IDLE_PAUSE = 4;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_t;

    typedef struct packed {
        row_op_t    op;
        row_chk_t   mode;
        logic [7:0] value;
        reg_index_t idx;
        logic [63:0] cfg;
        result_t    res;
    } step_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [7:0]                in_byte = 8'h00;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                kind;
    logic [7:0]                data_byte;
    logic [7:0]                field_number;
    logic                      last;

    // tokenizer state and register copies
    logic [255:0] delim_set = '0;
    logic [7:0]   field_limit = MAX_FIELDS_RESET;
    logic         quoted = 1'b0;
    logic         escaped = 1'b0;
    logic         in_octal = 1'b0;
    logic [7:0]   octal_acc = 8'h00;
    logic         field_start = 1'b1;
    logic [7:0]   field_idx = 8'h00;
    logic         dropping = 1'b0;

    result_t step_tokens[$];
    result_t tokens_due[$];
    step_t   script[$];
    int      fail_cnt = 0;
    int      tokens_seen = 0;
    int      bytes_sent = 0;
    int      units_in_phase = 0;
    int      cycle_cnt = 0;

    quoted_escaped_field_splitter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_record();
        quoted      = 1'b0;
        escaped     = 1'b0;
        in_octal    = 1'b0;
        octal_acc   = 8'h00;
        field_start = 1'b1;
        field_idx   = 8'h00;
        dropping    = 1'b0;
    endfunction

    function automatic void emit(kind_t k, logic [7:0] d, logic [7:0] f);
        result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.field_number = f;
        r.last         = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void seal();
        result_t r;
        if (step_tokens.size() != 0)
        begin
            r = step_tokens.pop_back();
            r.last = 1'b1;
            step_tokens.push_back(r);
        end
    endfunction

    function automatic void finish_record();
        emit(KIND_RECORD_END, 8'h00, field_idx + 8'd1);
        clear_record();
    endfunction

    // advance the tokenizer by one byte and collect its results
    function automatic void tokenize_byte(input logic [7:0] b);
        step_tokens.delete();
        if (dropping)
        begin
            if (b == CH_NUL)
                clear_record();
            return;
        end
        if (field_start)
        begin
            if (int'(field_idx) + 2 >= int'(field_limit))
            begin
                emit(KIND_ERROR, 8'h00, field_idx);
                if (b == CH_NUL)
                    clear_record();
                else
                    dropping = 1'b1;
                seal();
                return;
            end
            if (b == CH_SPACE || b == CH_TAB)
                return;
            field_start = 1'b0;
        end
        if (escaped)
        begin
            escaped = 1'b0;
            if (b == CH_NUL)
                finish_record();
            else if (b >= CH_ZERO && b <= CH_SEVEN)
            begin
                in_octal  = 1'b1;
                octal_acc = b - CH_ZERO;
            end
            else
            begin
                case (b)
                    CH_LOWER_B: emit(KIND_DATA, CH_BS, field_idx);
                    CH_LOWER_N: emit(KIND_DATA, CH_LF, field_idx);
                    CH_LOWER_R: emit(KIND_DATA, CH_CR, field_idx);
                    CH_LOWER_T: emit(KIND_DATA, CH_TAB, field_idx);
                    default:    emit(KIND_DATA, b, field_idx);
                endcase
            end
            seal();
            return;
        end
        if (in_octal)
        begin
            if (b >= CH_ZERO && b <= CH_SEVEN)
            begin
                octal_acc = {octal_acc[4:0], b[2:0]};
                return;
            end
            emit(KIND_DATA, octal_acc, field_idx);
            in_octal  = 1'b0;
            octal_acc = 8'h00;
        end
        if (b == CH_NUL)
            finish_record();
        else if (delim_set[b])
        begin
            if (quoted)
                emit(KIND_DATA, b, field_idx);
            else
            begin
                emit(KIND_FIELD_END, 8'h00, field_idx);
                field_idx   = field_idx + 8'd1;
                field_start = 1'b1;
            end
        end
        else if (b == CH_QUOTE)
            quoted = !quoted;
        else if (b == CH_BACKSLASH)
            escaped = 1'b1;
        else
            emit(KIND_DATA, b, field_idx);
        seal();
    endfunction

    function automatic logic [7:0] pick_delim();
        logic [7:0] c;
        for (int i = 0; i < 16; i++)
        begin
            c = 8'($urandom_range(1, 255));
            if (delim_set[c])
                return c;
        end
        return CH_COMMA;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void put_cfg(reg_index_t idx, logic [63:0] v);
        step_t s;
        s = '0;
        s.op  = ROW_CFG;
        s.idx = idx;
        s.cfg = v;
        script.push_back(s);
    endfunction

    function automatic void put_byte(logic [7:0] b, row_chk_t mode, kind_t k,
                                     logic [7:0] d, logic [7:0] f);
        step_t s;
        s = '0;
        s.op                 = ROW_BYTE;
        s.mode               = mode;
        s.value              = b;
        s.res.kind           = k;
        s.res.data_byte      = d;
        s.res.field_number   = f;
        s.res.last           = 1'b1;
        script.push_back(s);
    endfunction

    task automatic offer(input logic [7:0] b);
        int gap;
        gap = 0;
        if ((bytes_sent < 700 || bytes_sent >= 1000) && $urandom_range(99) < 10)
            gap = $urandom_range(1, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        offer(b);
        tokenize_byte(b);
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
        units_in_phase++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] v);
        in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DELIM_MAP_0: delim_set[63:0]    = v;
            REG_DELIM_MAP_1: delim_set[127:64]  = v;
            REG_DELIM_MAP_2: delim_set[191:128] = v;
            REG_DELIM_MAP_3: delim_set[255:192] = v;
            REG_MAX_FIELDS:  field_limit        = v[7:0];
            default: ;
        endcase
    endtask

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : token_sink
        result_t want;
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                tokens_seen++;
                if (tokens_due.size() == 0)
                begin
                    $error("unexpected token: kind %0d data %0d field %0d last %0d",
                           kind, data_byte, field_number, last);
                    fail_cnt++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("kind", 8'(want.kind), 8'(kind));
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("field_number", want.field_number, field_number);
                    check_field("last", 8'(want.last), 8'(last));
                end
            end
            if (!held && tokens_seen == 300)
            begin
                held = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (tokens_seen >= 700 && tokens_seen < 1000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 17);
        end
    end

    initial
    begin : stimulus
        step_t       st;
        logic [63:0] m0, m1, m2, m3;
        logic [7:0]  mf;
        logic [7:0]  esc;
        int          budget;
        int          nfields;

        put_cfg(REG_DELIM_MAP_0, (64'd1 << CH_SPACE) | (64'd1 << CH_TAB)
                                 | (64'd1 << CH_COMMA) | 64'd1);
        put_cfg(REG_DELIM_MAP_1, 64'd0);
        put_cfg(REG_DELIM_MAP_2, 64'd0);
        put_cfg(REG_DELIM_MAP_3, 64'd0);
        put_cfg(REG_MAX_FIELDS, 64'(MAX_FIELDS_RESET));
        put_byte(CH_SPACE, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_TAB, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte("a", CHK_ONE, KIND_DATA, "a", 8'd0);
        put_byte(8'hFF, CHK_ONE, KIND_DATA, 8'hFF, 8'd0);
        put_byte(CH_COMMA, CHK_ONE, KIND_FIELD_END, 8'h00, 8'd0);
        put_byte(CH_QUOTE, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_COMMA, CHK_ONE, KIND_DATA, CH_COMMA, 8'd1);
        put_byte(CH_QUOTE, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_BACKSLASH, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_LOWER_N, CHK_ONE, KIND_DATA, CH_LF, 8'd1);
        put_byte(CH_BACKSLASH, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_LOWER_B, CHK_ONE, KIND_DATA, CH_BS, 8'd1);
        put_byte(CH_BACKSLASH, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_LOWER_T, CHK_ONE, KIND_DATA, CH_TAB, 8'd1);
        put_byte(CH_BACKSLASH, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte("3", CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_SEVEN, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_SEVEN, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte("x", CHK_MODEL, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_BACKSLASH, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_NUL, CHK_ONE, KIND_RECORD_END, 8'h00, 8'd2);
        put_cfg(REG_MAX_FIELDS, 64'd2);
        put_byte("a", CHK_ONE, KIND_ERROR, 8'h00, 8'd0);
        put_byte(CH_NUL, CHK_NONE, KIND_DATA, 8'h00, 8'd0);
        put_byte(CH_NUL, CHK_ONE, KIND_ERROR, 8'h00, 8'd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            st = script[i];
            if (st.op == ROW_CFG)
                write_reg(st.idx, st.cfg);
            else
            begin
                offer(st.value);
                tokenize_byte(st.value);
                if (st.mode == CHK_MODEL)
                    foreach (step_tokens[j])
                        tokens_due.push_back(step_tokens[j]);
                else if (st.mode == CHK_ONE)
                    tokens_due.push_back(st.res);
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            m1 = 64'd0;
            m2 = 64'd0;
            m3 = 64'd0;
            budget = 330;
            case (p)
                0:
                begin
                    m0 = (64'd1 << CH_SPACE) | (64'd1 << CH_TAB)
                         | (64'd1 << CH_COMMA) | (64'd1 << CH_COLON);
                    mf = MAX_FIELDS_RESET;
                end
                1:
                begin
                    m0 = '1;
                    m1 = '1;
                    m2 = '1;
                    m3 = '1;
                    mf = 8'd255;
                end
                2:
                begin
                    m0 = 64'd0;
                    mf = 8'd0;
                    budget = 100;
                end
                3:
                begin
                    m0 = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                    m1 = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                    m2 = {$urandom, $urandom} & {$urandom, $urandom};
                    m3 = {$urandom, $urandom} & {$urandom, $urandom};
                    mf = 8'($urandom_range(3, 8));
                end
                4:
                begin
                    m0 = (64'd1 << CH_SPACE) | (64'd1 << CH_COMMA) | (64'd1 << CH_QUOTE);
                    m1 = 64'd1 << (CH_BACKSLASH - 8'd64);
                    mf = 8'd3;
                    budget = 300;
                end
                default:
                begin
                    m0 = {$urandom, $urandom};
                    m1 = {$urandom, $urandom};
                    m2 = {$urandom, $urandom};
                    m3 = {$urandom, $urandom};
                    mf = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_DELIM_MAP_0, m0);
            write_reg(REG_DELIM_MAP_1, m1);
            write_reg(REG_DELIM_MAP_2, m2);
            write_reg(REG_DELIM_MAP_3, m3);
            write_reg(REG_MAX_FIELDS, 64'(mf));
            units_in_phase = 0;

            while (units_in_phase < budget)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 8))
                        feed($urandom_range(0, 7) == 0 ? CH_NUL : 8'($urandom_range(0, 255)));
                end
                else
                begin
                    nfields = $urandom_range(0, 6);
                    for (int f = 0; f <= nfields; f++)
                    begin
                        repeat ($urandom_range(0, 2))
                            feed($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                        repeat ($urandom_range(0, 6))
                        begin
                            case ($urandom_range(0, 9))
                                0, 1, 2: feed(8'($urandom_range(8'h21, 8'h7E)));
                                3: feed(8'($urandom_range(1, 255)));
                                4:
                                begin
                                    feed(CH_QUOTE);
                                    feed(pick_delim());
                                    feed(8'($urandom_range(1, 255)));
                                    feed(CH_QUOTE);
                                end
                                5, 6:
                                begin
                                    case ($urandom_range(0, 6))
                                        0: esc = CH_LOWER_B;
                                        1: esc = CH_LOWER_N;
                                        2: esc = CH_LOWER_R;
                                        3: esc = CH_LOWER_T;
                                        4: esc = CH_QUOTE;
                                        5: esc = CH_BACKSLASH;
                                        default: esc = 8'($urandom_range(1, 255));
                                    endcase
                                    feed(CH_BACKSLASH);
                                    feed(esc);
                                end
                                7:
                                begin
                                    feed(CH_BACKSLASH);
                                    repeat ($urandom_range(1, 4))
                                        feed(CH_ZERO + 8'($urandom_range(0, 7)));
                                end
                                8: feed(CH_QUOTE);
                                default: feed(pick_delim());
                            endcase
                        end
                        if (f < nfields)
                            feed(pick_delim());
                    end
                    case ($urandom_range(0, 9))
                        0: feed(CH_BACKSLASH);
                        1:
                        begin
                            feed(CH_BACKSLASH);
                            feed(CH_ZERO + 8'($urandom_range(0, 7)));
                        end
                        2: feed(CH_QUOTE);
                        default: ;
                    endcase
                    feed(CH_NUL);
                end
            end
        end

        in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
